FILE: rtl/pcwc_pkg.sv
package pcwc_pkg;

	localparam int ROW_W   = 40;
	localparam int WIN_W   = 24;
	localparam int FRAC_W  = 16;
	localparam int COL_W   = 16;
	localparam int SUM_W   = WIN_W + FRAC_W + 1;
	localparam int BETA_W  = FRAC_W + 1;
	localparam int RUN_W   = 14;
	localparam int CFG_W   = 40;
	localparam int DIVA_W  = 48;
	localparam int DIVB_W  = 32;
	localparam int RES_N   = 4;

	localparam logic [2:0] REG_FIRST   = 3'd0;
	localparam logic [2:0] REG_LAST    = 3'd1;
	localparam logic [2:0] REG_WINDOW  = 3'd2;
	localparam logic [2:0] REG_LIMIT   = 3'd3;
	localparam logic [2:0] REG_GRAN    = 3'd4;

	localparam logic [3:0] SYM_NONE = 4'd0;
	localparam logic [3:0] SYM_LOW  = 4'd1;
	localparam logic [3:0] SYM_MED  = 4'd2;
	localparam logic [3:0] SYM_HIGH = 4'd3;
	localparam logic [3:0] SYM_DEC0 = 4'd4;

	localparam logic [23:0] HIGH_TH = 24'd4390912;
	localparam logic [23:0] MED_TH  = 24'd2162688;

	typedef logic [3:0] cmd_t;

	localparam cmd_t CMD_NONE    = 4'd0;
	localparam cmd_t CMD_LOAD    = 4'd1;
	localparam cmd_t CMD_DECODE  = 4'd2;
	localparam cmd_t CMD_BETA_WB = 4'd3;
	localparam cmd_t CMD_SKIP    = 4'd4;
	localparam cmd_t CMD_TAKE    = 4'd5;
	localparam cmd_t CMD_ZDIV    = 4'd6;
	localparam cmd_t CMD_ZWB     = 4'd7;
	localparam cmd_t CMD_ZSUB    = 4'd8;
	localparam cmd_t CMD_ADD     = 4'd9;
	localparam cmd_t CMD_CLOSE0  = 4'd10;
	localparam cmd_t CMD_AVG     = 4'd11;
	localparam cmd_t CMD_AVG_WB  = 4'd12;
	localparam cmd_t CMD_FIN     = 4'd13;
	localparam cmd_t CMD_EOSCLR  = 4'd14;
	localparam cmd_t CMD_EMIT    = 4'd15;

	typedef struct packed {
		logic fin;
		logic rdy;
		logic div_busy;
		logic below;
		logic rows_zero;
		logic row_gt_last;
		logic past;
		logic n_zero;
		logic at_limit;
		logic wleft_zero;
		logic zrun_ok;
		logic valid_zero;
		logic fill_nz;
		logic eos;
		logic drain_end;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/pcwc_div.sv
module pcwc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pcwc_pkg::DIVA_W-1:0]     dividend,
	input  logic [pcwc_pkg::DIVB_W-1:0]     divisor,
	output logic                            busy,
	output logic [pcwc_pkg::DIVA_W-1:0]     quotient
);

	logic [pcwc_pkg::DIVA_W-1:0] dvd_q;
	logic [pcwc_pkg::DIVB_W-1:0] rem_q;
	logic [pcwc_pkg::DIVB_W-1:0] dvs_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic [pcwc_pkg::DIVB_W:0]   r2;
	logic [pcwc_pkg::DIVB_W:0]   diff;
	logic                        ge;

	assign r2   = {rem_q, dvd_q[pcwc_pkg::DIVA_W-1]};
	assign diff = r2 - {1'b0, dvs_q};
	assign ge   = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(pcwc_pkg::DIVA_W);
			dvd_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pcwc_pkg::DIVA_W-2:0], ge};
			rem_q <= ge ? diff[pcwc_pkg::DIVB_W-1:0] : r2[pcwc_pkg::DIVB_W-1:0];
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

FILE: rtl/pcwc_dp.sv
module pcwc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcwc_pkg::cmd_t                cmd,
	output pcwc_pkg::stat_t               stat,
	input  logic [7:0]                    in_byte,
	input  logic                          in_eos,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [pcwc_pkg::CFG_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    out_sym,
	output logic [15:0]                   out_cnt,
	output logic                          out_last
);

	localparam int ROW_W  = pcwc_pkg::ROW_W;
	localparam int WIN_W  = pcwc_pkg::WIN_W;
	localparam int COL_W  = pcwc_pkg::COL_W;
	localparam int SUM_W  = pcwc_pkg::SUM_W;
	localparam int BETA_W = pcwc_pkg::BETA_W;
	localparam int RUN_W  = pcwc_pkg::RUN_W;

	logic [ROW_W-1:0]  first_q, last_q;
	logic [WIN_W-1:0]  win_q;
	logic [COL_W-1:0]  lim_q;
	logic              gran_q;

	logic [63:0]       rec_q;
	logic [3:0]        pend_q;
	logic              rdy_q, eos_q, fin_q, cov_q, below_q, past_q;
	logic [ROW_W-1:0]  row_q;
	logic [RUN_W-1:0]  rows_q, n_q, prod_q;
	logic [BETA_W-1:0] beta_q;
	logic [SUM_W-1:0]  sum_q;
	logic [WIN_W-1:0]  valid_q, fill_q;
	logic [COL_W-1:0]  cols_q;

	logic [3:0]        rsym_q [pcwc_pkg::RES_N];
	logic [15:0]       rcnt_q [pcwc_pkg::RES_N];
	logic [2:0]        res_n_q, idx_q;
	logic [3:0]        lsym_q;
	logic [15:0]       lcnt_q;

	logic              ovalid_q, olast_q;
	logic [3:0]        osym_q;
	logic [15:0]       ocnt_q;

	logic [63:0]       newrec;
	logic [3:0]        pend_new, need;
	logic [RUN_W-1:0]  rows_dec;
	logic [30:0]       m_dec, u_dec;
	logic [31:0]       mu;
	logic              cov_dec;
	logic [WIN_W-1:0]  ws, wleft;
	logic [ROW_W-1:0]  diff;
	logic [RUN_W-1:0]  skip, take, t;
	logic [ROW_W:0]    avail;
	logic [COL_W-1:0]  room, kk;
	logic [39:0]       prod;
	logic [16:0]       avg;
	logic [20:0]       p10;
	logic [23:0]       p100;
	logic [3:0]        dsat, sym_avg;
	logic              div_start, div_busy;
	logic [pcwc_pkg::DIVA_W-1:0] div_a, div_q;
	logic [pcwc_pkg::DIVB_W-1:0] div_b;
	logic              push_en, merge;
	logic [3:0]        push_sym;
	logic [15:0]       push_cnt, msat;
	logic [16:0]       msum;

	always_comb begin
		newrec = ((pend_q == 4'd0) ? 64'd0 : rec_q)
			| ({56'd0, in_byte} << {pend_q[2:0], 3'b000});
		pend_new = pend_q + 4'd1;
		case (newrec[1:0])
			2'd1:    need = 4'd1;
			2'd3:    need = 4'd8;
			default: need = 4'd2;
		endcase
	end

	always_comb begin
		rows_dec = 14'd1;
		m_dec    = '0;
		u_dec    = '0;
		case (rec_q[1:0])
			2'd0: begin
				rows_dec = rec_q[15:2];
			end
			2'd1: begin
				m_dec = {28'd0, rec_q[7:5]};
				u_dec = {28'd0, rec_q[4:2]};
			end
			2'd2: begin
				m_dec = {24'd0, rec_q[15:9]};
				u_dec = {24'd0, rec_q[8:2]};
			end
			default: begin
				m_dec = rec_q[63:33];
				u_dec = rec_q[32:2];
			end
		endcase
		mu      = {1'b0, m_dec} + {1'b0, u_dec};
		cov_dec = mu != 32'd0;
	end

	assign ws    = (win_q == '0) ? WIN_W'(1) : win_q;
	assign wleft = ws - fill_q;
	assign diff  = first_q - row_q;
	assign skip  = (diff < ROW_W'(rows_q)) ? diff[RUN_W-1:0] : rows_q;
	assign avail = {1'b0, last_q} - {1'b0, row_q} + (ROW_W+1)'(1);
	assign take  = ((ROW_W+1)'(rows_q) < avail) ? rows_q : avail[RUN_W-1:0];
	assign t     = (WIN_W'(n_q) < wleft) ? n_q : wleft[RUN_W-1:0];
	assign room  = lim_q - cols_q;
	assign kk    = (COL_W'(div_q[RUN_W-1:0]) > room) ? room : COL_W'(div_q[RUN_W-1:0]);
	assign prod  = 40'(kk) * 40'(ws);

	assign avg  = div_q[16:0];
	assign p10  = 21'(avg) * 21'd10;
	assign p100 = 24'(avg) * 24'd100;
	assign dsat = (p10[20:16] > 5'd9) ? 4'd9 : p10[19:16];

	always_comb begin
		if (gran_q) begin
			sym_avg = pcwc_pkg::SYM_DEC0 + dsat;
		end else if (p100 > pcwc_pkg::HIGH_TH) begin
			sym_avg = pcwc_pkg::SYM_HIGH;
		end else if (p100 > pcwc_pkg::MED_TH) begin
			sym_avg = pcwc_pkg::SYM_MED;
		end else begin
			sym_avg = pcwc_pkg::SYM_LOW;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_a     = {1'b0, m_dec, 16'd0};
		div_b     = mu;
		case (cmd)
			pcwc_pkg::CMD_DECODE: begin
				div_start = 1'b1;
			end
			pcwc_pkg::CMD_ZDIV: begin
				div_start = 1'b1;
				div_a     = pcwc_pkg::DIVA_W'(n_q);
				div_b     = pcwc_pkg::DIVB_W'(ws);
			end
			pcwc_pkg::CMD_AVG: begin
				div_start = 1'b1;
				div_a     = pcwc_pkg::DIVA_W'(sum_q);
				div_b     = pcwc_pkg::DIVB_W'(valid_q);
			end
			default: begin
			end
		endcase
	end

	pcwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_comb begin
		push_en  = 1'b0;
		push_sym = pcwc_pkg::SYM_NONE;
		push_cnt = 16'd1;
		case (cmd)
			pcwc_pkg::CMD_ZWB: begin
				push_en  = 1'b1;
				push_cnt = kk;
			end
			pcwc_pkg::CMD_CLOSE0: begin
				push_en = 1'b1;
			end
			pcwc_pkg::CMD_AVG_WB: begin
				push_en  = 1'b1;
				push_sym = sym_avg;
			end
			pcwc_pkg::CMD_FIN: begin
				push_en  = res_n_q == 3'd0;
				push_cnt = 16'd0;
			end
			default: begin
			end
		endcase
		merge = (res_n_q != 3'd0) && (push_sym == pcwc_pkg::SYM_NONE)
			&& (lsym_q == pcwc_pkg::SYM_NONE);
		msum  = {1'b0, lcnt_q} + {1'b0, push_cnt};
		msat  = msum[16] ? 16'hffff : msum[15:0];
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			if (merge) begin
				rcnt_q[2'(res_n_q - 3'd1)] <= msat;
			end else if (res_n_q < 3'(pcwc_pkg::RES_N)) begin
				rsym_q[res_n_q[1:0]] <= push_sym;
				rcnt_q[res_n_q[1:0]] <= push_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			last_q   <= '0;
			win_q    <= WIN_W'(1);
			lim_q    <= COL_W'(80);
			gran_q   <= 1'b0;
			rec_q    <= '0;
			pend_q   <= '0;
			rdy_q    <= 1'b0;
			eos_q    <= 1'b0;
			fin_q    <= 1'b0;
			cov_q    <= 1'b0;
			below_q  <= 1'b0;
			past_q   <= 1'b0;
			row_q    <= '0;
			rows_q   <= '0;
			n_q      <= '0;
			prod_q   <= '0;
			beta_q   <= '0;
			sum_q    <= '0;
			valid_q  <= '0;
			fill_q   <= '0;
			cols_q   <= '0;
			res_n_q  <= '0;
			idx_q    <= '0;
			lsym_q   <= '0;
			lcnt_q   <= '0;
			ovalid_q <= 1'b0;
			olast_q  <= 1'b0;
			osym_q   <= '0;
			ocnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					pcwc_pkg::REG_FIRST:  first_q <= cfg_data[ROW_W-1:0];
					pcwc_pkg::REG_LAST:   last_q  <= cfg_data[ROW_W-1:0];
					pcwc_pkg::REG_WINDOW: win_q   <= cfg_data[WIN_W-1:0];
					pcwc_pkg::REG_LIMIT:  lim_q   <= cfg_data[COL_W-1:0];
					pcwc_pkg::REG_GRAN:   gran_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (push_en) begin
				if (merge) begin
					lcnt_q <= msat;
				end else if (res_n_q < 3'(pcwc_pkg::RES_N)) begin
					lsym_q  <= push_sym;
					lcnt_q  <= push_cnt;
					res_n_q <= res_n_q + 3'd1;
				end
			end

			if (ovalid_q && out_ready && (cmd != pcwc_pkg::CMD_EMIT)) begin
				ovalid_q <= 1'b0;
			end

			case (cmd)
				pcwc_pkg::CMD_LOAD: begin
					res_n_q <= '0;
					idx_q   <= '0;
					eos_q   <= in_eos;
					if (!fin_q) begin
						rec_q <= newrec;
						if (pend_new >= need) begin
							pend_q <= '0;
							rdy_q  <= 1'b1;
						end else begin
							pend_q <= pend_new;
							rdy_q  <= 1'b0;
						end
					end
				end
				pcwc_pkg::CMD_DECODE: begin
					rows_q <= rows_dec;
					cov_q  <= cov_dec;
				end
				pcwc_pkg::CMD_BETA_WB: begin
					beta_q <= cov_q ? div_q[BETA_W-1:0] : '0;
				end
				pcwc_pkg::CMD_SKIP: begin
					below_q <= row_q < first_q;
					if (row_q < first_q) begin
						row_q  <= row_q + ROW_W'(skip);
						rows_q <= rows_q - skip;
					end
				end
				pcwc_pkg::CMD_TAKE: begin
					n_q    <= take;
					past_q <= !((ROW_W+1)'(rows_q) < avail);
					row_q  <= row_q + ROW_W'(take);
				end
				pcwc_pkg::CMD_ZWB: begin
					cols_q <= cols_q + kk;
					prod_q <= prod[RUN_W-1:0];
				end
				pcwc_pkg::CMD_ZSUB: begin
					n_q <= n_q - prod_q;
				end
				pcwc_pkg::CMD_ADD: begin
					if (cov_q) begin
						sum_q   <= sum_q + SUM_W'(beta_q);
						valid_q <= valid_q + WIN_W'(t);
					end
					fill_q <= fill_q + WIN_W'(t);
					n_q    <= n_q - t;
				end
				pcwc_pkg::CMD_CLOSE0, pcwc_pkg::CMD_AVG_WB: begin
					cols_q  <= cols_q + COL_W'(1);
					sum_q   <= '0;
					valid_q <= '0;
					fill_q  <= '0;
				end
				pcwc_pkg::CMD_FIN: begin
					fin_q <= 1'b1;
				end
				pcwc_pkg::CMD_EOSCLR: begin
					if (eos_q) begin
						pend_q <= '0;
					end
				end
				pcwc_pkg::CMD_EMIT: begin
					ovalid_q <= 1'b1;
					osym_q   <= rsym_q[idx_q[1:0]];
					ocnt_q   <= rcnt_q[idx_q[1:0]];
					olast_q  <= fin_q && (idx_q == res_n_q - 3'd1);
					idx_q    <= idx_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.fin         = fin_q;
		stat.rdy         = rdy_q;
		stat.div_busy    = div_busy;
		stat.below       = below_q;
		stat.rows_zero   = rows_q == '0;
		stat.row_gt_last = row_q > last_q;
		stat.past        = past_q;
		stat.n_zero      = n_q == '0;
		stat.at_limit    = cols_q >= lim_q;
		stat.wleft_zero  = fill_q >= ws;
		stat.zrun_ok     = (fill_q == '0) && !cov_q && (WIN_W'(n_q) >= ws);
		stat.valid_zero  = valid_q == '0;
		stat.fill_nz     = fill_q != '0;
		stat.eos         = eos_q;
		stat.drain_end   = idx_q == res_n_q;
		stat.out_free    = !ovalid_q || out_ready;
	end

	assign out_valid = ovalid_q;
	assign out_sym   = osym_q;
	assign out_cnt   = ocnt_q;
	assign out_last  = olast_q;

endmodule

FILE: rtl/pcwc_ctrl.sv
module pcwc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcwc_pkg::stat_t  stat,
	output pcwc_pkg::cmd_t   cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ROUTE  = 4'd1;
	localparam logic [3:0] ST_DEC    = 4'd2;
	localparam logic [3:0] ST_BWAIT  = 4'd3;
	localparam logic [3:0] ST_SKIP   = 4'd4;
	localparam logic [3:0] ST_RCHK   = 4'd5;
	localparam logic [3:0] ST_FEED   = 4'd6;
	localparam logic [3:0] ST_ADDCHK = 4'd7;
	localparam logic [3:0] ST_ZWAIT  = 4'd8;
	localparam logic [3:0] ST_ZSUB   = 4'd9;
	localparam logic [3:0] ST_CLOSE  = 4'd10;
	localparam logic [3:0] ST_AWAIT  = 4'd11;
	localparam logic [3:0] ST_FINISH = 4'd12;
	localparam logic [3:0] ST_FIN2   = 4'd13;
	localparam logic [3:0] ST_ENDCHK = 4'd14;
	localparam logic [3:0] ST_DRAIN  = 4'd15;

	logic [3:0] state_q, state_d;
	logic       ret_q, ret_d;
	logic [3:0] after_close;

	assign after_close = ret_q ? ST_FIN2 : ST_FEED;
	assign in_ready    = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = pcwc_pkg::CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd     = pcwc_pkg::CMD_LOAD;
					state_d = stat.fin ? ST_IDLE : ST_ROUTE;
				end
			end
			ST_ROUTE: begin
				state_d = stat.rdy ? ST_DEC : ST_ENDCHK;
			end
			ST_DEC: begin
				cmd     = pcwc_pkg::CMD_DECODE;
				state_d = ST_BWAIT;
			end
			ST_BWAIT: begin
				if (!stat.div_busy) begin
					cmd     = pcwc_pkg::CMD_BETA_WB;
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				cmd     = pcwc_pkg::CMD_SKIP;
				state_d = ST_RCHK;
			end
			ST_RCHK: begin
				if (stat.below && stat.rows_zero) begin
					state_d = ST_ENDCHK;
				end else if (stat.row_gt_last) begin
					state_d = ST_FINISH;
				end else begin
					cmd     = pcwc_pkg::CMD_TAKE;
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				if (stat.n_zero || stat.at_limit) begin
					state_d = stat.past ? ST_FINISH : ST_ENDCHK;
				end else if (stat.wleft_zero) begin
					ret_d   = 1'b0;
					state_d = ST_CLOSE;
				end else if (stat.zrun_ok) begin
					cmd     = pcwc_pkg::CMD_ZDIV;
					state_d = ST_ZWAIT;
				end else begin
					cmd     = pcwc_pkg::CMD_ADD;
					state_d = ST_ADDCHK;
				end
			end
			ST_ADDCHK: begin
				if (stat.wleft_zero) begin
					ret_d   = 1'b0;
					state_d = ST_CLOSE;
				end else begin
					state_d = ST_FEED;
				end
			end
			ST_ZWAIT: begin
				if (!stat.div_busy) begin
					cmd     = pcwc_pkg::CMD_ZWB;
					state_d = ST_ZSUB;
				end
			end
			ST_ZSUB: begin
				cmd     = pcwc_pkg::CMD_ZSUB;
				state_d = ST_FEED;
			end
			ST_CLOSE: begin
				if (stat.valid_zero) begin
					cmd     = pcwc_pkg::CMD_CLOSE0;
					state_d = after_close;
				end else begin
					cmd     = pcwc_pkg::CMD_AVG;
					state_d = ST_AWAIT;
				end
			end
			ST_AWAIT: begin
				if (!stat.div_busy) begin
					cmd     = pcwc_pkg::CMD_AVG_WB;
					state_d = after_close;
				end
			end
			ST_FINISH: begin
				if (stat.fill_nz && !stat.at_limit) begin
					ret_d   = 1'b1;
					state_d = ST_CLOSE;
				end else begin
					state_d = ST_FIN2;
				end
			end
			ST_FIN2: begin
				cmd     = pcwc_pkg::CMD_FIN;
				state_d = ST_ENDCHK;
			end
			ST_ENDCHK: begin
				if (!stat.fin && (stat.at_limit || stat.eos)) begin
					cmd     = pcwc_pkg::CMD_EOSCLR;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.drain_end) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd = pcwc_pkg::CMD_EMIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

FILE: rtl/packed_count_window_classifier_core.sv
// A byte that completes a count record waits on the serial divider for beta before the next
// request is taken; each window closed with coverage adds a further division for the average,
// and so does a long zero run. Throughput: one byte at a time, set by the shared radix-2
// divider; results drain one per cycle afterward while the output accepts them. Reset clears
// all state except the result buffer; registers return to defaults.
module packed_count_window_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // stream_byte
	input  logic                          s_tlast,   // end_of_stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // symbol[3:0], repeat_count[19:4], zero pad
	output logic                          m_tlast,   // region_done
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [pcwc_pkg::CFG_W-1:0]    cfg_data
);

	pcwc_pkg::cmd_t  cmd;
	pcwc_pkg::stat_t stat;
	logic [3:0]      sym;
	logic [15:0]     cnt;

	pcwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pcwc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.in_eos    (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sym   (sym),
		.out_cnt   (cnt),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, cnt, sym};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] REC_ZRUN = 2'd0;
	localparam logic [1:0] REC_ONE  = 2'd1;
	localparam logic [1:0] REC_TWO  = 2'd2;
	localparam logic [1:0] REC_WIDE = 2'd3;

	localparam longint unsigned ROW_MASK = 64'hFF_FFFF_FFFF;
	localparam longint unsigned WIN_MASK = 64'hFF_FFFF;
	localparam longint unsigned SUM_MASK = (64'd1 << pcwc_pkg::SUM_W) - 1;
	localparam longint unsigned COL_MASK = 64'hFFFF;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 200;

	class window_scoreboard;
		typedef struct {
			logic [3:0]  sym;
			logic [15:0] cnt;
			logic        done;
		} column_t;

		longint unsigned lo_row, hi_row, win_len, col_limit, gran;
		longint unsigned rec_bits, pending, row_ctr, beta, covered;
		longint unsigned win_sum, win_valid, win_fill, cols, finished;
		column_t step_cols[$];
		column_t expected_cols[$];
		int errors;

		function new();
			lo_row = 0; hi_row = 0; win_len = 1; col_limit = 80; gran = 0;
			rec_bits = 0; pending = 0; row_ctr = 0; beta = 0; covered = 0;
			win_sum = 0; win_valid = 0; win_fill = 0; cols = 0; finished = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, longint unsigned v);
			case (idx)
				pcwc_pkg::REG_FIRST:  lo_row = v & ROW_MASK;
				pcwc_pkg::REG_LAST:   hi_row = v & ROW_MASK;
				pcwc_pkg::REG_WINDOW: win_len = v & WIN_MASK;
				pcwc_pkg::REG_LIMIT:  col_limit = v & COL_MASK;
				pcwc_pkg::REG_GRAN:   gran = v & 1;
				default:    ;
			endcase
		endfunction

		function void add_column(logic [3:0] sym, longint unsigned cnt);
			column_t c;
			int n;
			n = step_cols.size();
			if (n > 0 && sym == pcwc_pkg::SYM_NONE
				&& step_cols[n-1].sym == pcwc_pkg::SYM_NONE) begin
				cnt = cnt + step_cols[n-1].cnt;
				step_cols[n-1].cnt = cnt > 65535 ? 16'hFFFF : cnt[15:0];
			end else if (n < pcwc_pkg::RES_N) begin
				c.sym = sym;
				c.cnt = cnt > 65535 ? 16'hFFFF : cnt[15:0];
				c.done = 0;
				step_cols.push_back(c);
			end
		endfunction

		function logic [3:0] classify();
			longint unsigned avg, d;
			if (win_valid == 0)
				return pcwc_pkg::SYM_NONE;
			avg = win_sum / win_valid;
			if (gran) begin
				d = (avg * 10) >> pcwc_pkg::FRAC_W;
				if (d > 9)
					d = 9;
				return pcwc_pkg::SYM_DEC0 + d[3:0];
			end
			if (avg * 100 > 67 * (64'd1 << pcwc_pkg::FRAC_W))
				return pcwc_pkg::SYM_HIGH;
			if (avg * 100 > 33 * (64'd1 << pcwc_pkg::FRAC_W))
				return pcwc_pkg::SYM_MED;
			return pcwc_pkg::SYM_LOW;
		endfunction

		function void close_window();
			add_column(classify(), 1);
			cols = (cols + 1) & COL_MASK;
			win_sum = 0; win_valid = 0; win_fill = 0;
		endfunction

		function void feed_rows(longint unsigned n);
			longint unsigned ws, wleft, t, k, room;
			ws = win_len ? win_len : 1;
			while (n > 0 && cols < col_limit) begin
				wleft = ws > win_fill ? ws - win_fill : 0;
				if (wleft == 0) begin
					close_window();
					continue;
				end
				if (win_fill == 0 && !covered && n >= ws) begin
					k = n / ws;
					room = col_limit - cols;
					if (k > room)
						k = room;
					add_column(pcwc_pkg::SYM_NONE, k);
					cols = (cols + k) & COL_MASK;
					n -= k * ws;
					continue;
				end
				t = n < wleft ? n : wleft;
				if (covered) begin
					win_sum = (win_sum + t * beta) & SUM_MASK;
					win_valid = (win_valid + t) & WIN_MASK;
				end
				win_fill += t;
				n -= t;
				if (win_fill >= ws)
					close_window();
			end
		endfunction

		function void finish_region();
			if (win_fill > 0 && cols < col_limit)
				close_window();
			if (step_cols.size() == 0)
				add_column(pcwc_pkg::SYM_NONE, 0);
			finished = 1;
		endfunction

		function void decode_record();
			longint unsigned v, rows, m, u, row, skip, avail, take;
			v = rec_bits; m = 0; u = 0; row = row_ctr;
			if (v[1:0] == REC_ZRUN) begin
				rows = (v & 64'hFFFF) >> 2;
			end else begin
				rows = 1;
				if (v[1:0] == REC_ONE) begin
					m = (v & 64'hFF) >> 5;
					u = (v >> 2) & 64'h7;
				end else if (v[1:0] == REC_TWO) begin
					u = ((v & 64'hFFFF) >> 2) & 64'h7F;
					m = (v & 64'hFFFF) >> 9;
				end else begin
					u = (v >> 2) & 64'h7FFF_FFFF;
					m = v >> 33;
				end
			end
			covered = (m + u) > 0;
			beta = covered ? (m << pcwc_pkg::FRAC_W) / (m + u) : 0;
			if (row < lo_row) begin
				skip = lo_row - row;
				if (skip > rows)
					skip = rows;
				row += skip;
				rows -= skip;
				row_ctr = row & ROW_MASK;
				if (rows == 0)
					return;
			end
			if (row > hi_row) begin
				finish_region();
				return;
			end
			avail = hi_row - row + 1;
			take = rows < avail ? rows : avail;
			feed_rows(take);
			row += take;
			row_ctr = row & ROW_MASK;
			if (row > hi_row)
				finish_region();
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			longint unsigned need;
			step_cols.delete();
			if (finished)
				return;
			if (pending == 0)
				rec_bits = 0;
			rec_bits |= longint'(b) << (8 * (pending & 7));
			pending++;
			need = rec_bits[1:0] == REC_ONE ? 1 : (rec_bits[1:0] == REC_WIDE ? 8 : 2);
			if (pending >= need) begin
				pending = 0;
				decode_record();
			end
			if (!finished && (cols >= col_limit || eos)) begin
				if (eos)
					pending = 0;
				finish_region();
			end
			foreach (step_cols[i]) begin
				step_cols[i].done = finished && i == step_cols.size() - 1;
				expected_cols.push_back(step_cols[i]);
			end
		endfunction

		function void check(logic [3:0] sym, logic [15:0] cnt, logic done);
			column_t e;
			if (expected_cols.size() == 0) begin
				$display("%0t: unexpected result sym=%0d cnt=%0d done=%0b",
					$time, sym, cnt, done);
				errors++;
				return;
			end
			e = expected_cols.pop_front();
			if (sym !== e.sym) begin
				$display("%0t: symbol exp %0d got %0d", $time, e.sym, sym);
				errors++;
			end
			if (cnt !== e.cnt) begin
				$display("%0t: repeat_count exp %0d got %0d", $time, e.cnt, cnt);
				errors++;
			end
			if (done !== e.done) begin
				$display("%0t: region_done exp %0b got %0b", $time, e.done, done);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [7:0] s_tdata = 0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 0;
	logic [2:0] cfg_addr = pcwc_pkg::REG_FIRST;
	logic [pcwc_pkg::CFG_W-1:0] cfg_data = 0;

	window_scoreboard sb = new();
	bit burst = 0;
	bit hold_req = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	packed_count_window_classifier_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = burst ? 0 : $urandom_range(0, 18);
			if (hold_req) begin
				gap += HOLD_CYCLES;
				hold_req = 0;
			end
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check(m_tdata[3:0], m_tdata[19:4], m_tlast);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		s_tlast <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, eos);
		bytes_sent++;
	endtask

	task automatic send_record(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			send_byte(v[8*i +: 8], 1'b0);
	endtask

	task automatic send_random_record();
		logic [63:0] v;
		int r;
		longint unsigned rows;
		r = $urandom_range(0, 99);
		v = {$urandom, $urandom};
		if (r < 40) begin
			v[1:0] = REC_ONE;
			send_record(v, 1);
		end else if (r < 65) begin
			v[1:0] = REC_TWO;
			send_record(v, 2);
		end else if (r < 80) begin
			v[1:0] = REC_WIDE;
			if ($urandom_range(0, 1))
				v[63:33] = 31'($urandom_range(0, 50));
			send_record(v, 8);
		end else begin
			rows = $urandom_range(0, 39) == 0 ? $urandom_range(0, 16383) : $urandom_range(0, 20);
			v = rows << 2;
			v[1:0] = REC_ZRUN;
			send_record(v, 2);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint unsigned v);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= v[pcwc_pkg::CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 0;
		cfg_we <= 0;
		@(posedge clk);
		while (sb.expected_cols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(pcwc_pkg::REG_FIRST, 0);
		write_reg(pcwc_pkg::REG_LAST, ROW_MASK);
		write_reg(pcwc_pkg::REG_WINDOW, 1);
		write_reg(pcwc_pkg::REG_LIMIT, 65535);
		write_reg(pcwc_pkg::REG_GRAN, 0);
		cfg_we <= 0;

		// uncovered row, full counts, pure high/low, half, two-byte max, wide max/zero
		send_record(64'h01, 1);
		send_record(64'hFD, 1);
		send_record(64'hE1, 1);
		send_record(64'h1D, 1);
		send_record(64'h6D, 1);
		send_record(64'hFFFE, 2);
		send_record(64'hFFFF_FFFF_FFFF_FFFF, 8);
		send_record(64'h03, 8);
		// empty run, short run, longest run
		send_record(64'h0000, 2);
		send_record(64'h0014, 2);
		send_record(64'hFFFC, 2);
		drain_and_settle();

		write_reg(pcwc_pkg::REG_WINDOW, 3);
		write_reg(pcwc_pkg::REG_GRAN, 1);
		drain_and_settle();
		burst = 1;
		while (bytes_sent < 55)
			send_random_record();
		burst = 0;
		hold_req = 1;
		while (bytes_sent < 75)
			send_random_record();
		drain_and_settle();

		write_reg(pcwc_pkg::REG_WINDOW, WIN_MASK);
		write_reg(pcwc_pkg::REG_GRAN, 0);
		drain_and_settle();
		for (int i = 0; i < 4; i++)
			send_random_record();
		drain_and_settle();

		// shrinking the window closes the overfull one at the next row
		write_reg(pcwc_pkg::REG_WINDOW, 2);
		write_reg(pcwc_pkg::REG_FIRST, ROW_MASK);
		drain_and_settle();
		send_record(64'h0050, 2);
		send_record(64'hFD, 1);
		drain_and_settle();
		write_reg(pcwc_pkg::REG_FIRST, 0);
		drain_and_settle();
		while (bytes_sent < 118)
			send_random_record();

		// truncated wide record at end of stream
		send_byte(8'h03, 1'b1);
		drain_and_settle();

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
